FILE: rtl/core/vbpps_pkg.sv
// Shared definitions for the video bus pattern and palette store.
// Holds operation codes, bus address constants, the palette mirroring
// function and the fixed master colour table. Depends on nothing else.
package vbpps_pkg;

    localparam int PATTERN_TABLE_BYTES = 4096;
    localparam int PALETTE_BYTES       = 32;

    localparam int BUS_AW   = 14;
    localparam int COLOR_W  = 6;
    localparam int RGB_W    = 24;
    localparam int VPAL_W   = 3;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_DRAW   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    localparam logic [BUS_AW-1:0] PATTERN_LAST = 14'h1FFF;
    localparam logic [BUS_AW-1:0] PALETTE_BASE = 14'h3F00;

    // Entries 0x10, 0x14, 0x18 and 0x1C alias the background colour entries.
    function automatic logic [4:0] palette_index(input logic [4:0] a);
        logic [4:0] r;
        r = a;
        if (a[4] && (a[1:0] == 2'b00))
        begin
            r = {1'b0, a[3:0]};
        end
        return r;
    endfunction

    function automatic logic [RGB_W-1:0] master_color(input logic [COLOR_W-1:0] cn);
        logic [RGB_W-1:0] c;
        case (cn)
            6'h00: c = 24'h545454;  6'h01: c = 24'h001E74;
            6'h02: c = 24'h081090;  6'h03: c = 24'h300088;
            6'h04: c = 24'h440064;  6'h05: c = 24'h5C0030;
            6'h06: c = 24'h540400;  6'h07: c = 24'h3C1800;
            6'h08: c = 24'h202A00;  6'h09: c = 24'h083A00;
            6'h0A: c = 24'h004000;  6'h0B: c = 24'h003C00;
            6'h0C: c = 24'h00323C;
            6'h10: c = 24'h989698;  6'h11: c = 24'h084CC4;
            6'h12: c = 24'h3032EC;  6'h13: c = 24'h5C1EE4;
            6'h14: c = 24'h8814B0;  6'h15: c = 24'hA01464;
            6'h16: c = 24'h982220;  6'h17: c = 24'h783C00;
            6'h18: c = 24'h545A00;  6'h19: c = 24'h287200;
            6'h1A: c = 24'h087C00;  6'h1B: c = 24'h007628;
            6'h1C: c = 24'h006678;
            6'h20: c = 24'hECEEEC;  6'h21: c = 24'h4C9AEC;
            6'h22: c = 24'h787CEC;  6'h23: c = 24'hB062EC;
            6'h24: c = 24'hE454EC;  6'h25: c = 24'hEC58B4;
            6'h26: c = 24'hEC6A64;  6'h27: c = 24'hD48820;
            6'h28: c = 24'hA0AA00;  6'h29: c = 24'h74C400;
            6'h2A: c = 24'h4CD020;  6'h2B: c = 24'h38CC6C;
            6'h2C: c = 24'h38B4CC;  6'h2D: c = 24'h3C3C3C;
            6'h30: c = 24'hECEEEC;  6'h31: c = 24'hA8CCEC;
            6'h32: c = 24'hBCBCEC;  6'h33: c = 24'hD4B2EC;
            6'h34: c = 24'hECAEEC;  6'h35: c = 24'hECAED4;
            6'h36: c = 24'hECB4B0;  6'h37: c = 24'hE4C490;
            6'h38: c = 24'hCCD278;  6'h39: c = 24'hB4DE78;
            6'h3A: c = 24'hA8E290;  6'h3B: c = 24'h98E2B4;
            6'h3C: c = 24'hA0D6E4;  6'h3D: c = 24'hA0A2A0;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/video_bus_pattern_palette_store.sv
// A bus write or an unused operation ends in ST_ISSUE, a bus read in ST_READ, and a
// pixel draw in ST_COLOR after ST_ISSUE, ST_HIGH and ST_PAL (three dependent reads
// of the single-ported pattern and palette memories, then the colour lookup).
// Throughput: one item at a time; the next start may be taken in the cycle the strobe shows.
// Reset clears the sequencer, the strobe and sets viewer_palette to 1; memory contents
// are undefined until written. Results cannot be stalled by the receiver.
module video_bus_pattern_palette_store #(
    parameter int PATTERN_TABLE_BYTES = vbpps_pkg::PATTERN_TABLE_BYTES,
    parameter int PALETTE_BYTES       = vbpps_pkg::PALETTE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: the single viewer palette register.
    input  logic        viewer_palette_we,
    input  logic [vbpps_pkg::VPAL_W-1:0] viewer_palette_wdata,
    // Command side.
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_value,
    input  logic        table_select,
    input  logic [6:0]  pixel_column,
    input  logic [6:0]  pixel_row,
    // Result side.
    output logic        done,
    output logic [7:0]  read_value,
    output logic [5:0]  color_number,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    // Both pattern tables together form one memory; the palette is a second memory.
    localparam int PAT_DEPTH = 2 * PATTERN_TABLE_BYTES;
    localparam int PAT_AW    = $clog2(PAT_DEPTH);
    localparam int PAL_AW    = $clog2(PALETTE_BYTES);

    // The sequencer walks through the memory accesses that one item needs.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ISSUE = 6'b000010,
        ST_READ  = 6'b000100,
        ST_HIGH  = 6'b001000,
        ST_PAL   = 6'b010000,
        ST_COLOR = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [vbpps_pkg::VPAL_W-1:0] viewer_palette_reg;

    // Captured command fields for the item in progress.
    logic [1:0]  op_reg;
    logic [13:0] addr_reg;
    logic [7:0]  wval_reg;
    logic        tsel_reg;
    logic [6:0]  col_reg;
    logic [6:0]  row_reg;
    logic        lsb_reg;

    logic [7:0]  pat_mem [PAT_DEPTH];
    logic [7:0]  pal_mem [PALETTE_BYTES];
    logic [7:0]  pat_rdata_reg;
    logic [7:0]  pal_rdata_reg;

    logic [PAT_AW-1:0] pat_raddr;
    logic [PAL_AW-1:0] pal_raddr;
    logic              pat_we;
    logic              pal_we;
    logic [PAT_AW-1:0] tile_lo;
    logic [PAT_AW-1:0] tile_hi;
    logic              in_pattern;
    logic              in_palette;
    logic              plane_bit;
    logic [1:0]        pixel;
    logic [5:0]        cn;
    logic [23:0]       rgb;

    logic        done_reg;
    logic [7:0]  read_value_reg;
    logic [5:0]  color_number_reg;
    logic [23:0] rgb_reg;

    logic accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Address decode of the captured bus address.
    assign in_pattern = (addr_reg <= vbpps_pkg::PATTERN_LAST);
    assign in_palette = (addr_reg >= vbpps_pkg::PALETTE_BASE);

    // Tile row address: table, tile row, tile column, bit plane, row within the tile.
    assign tile_lo = PAT_AW'({tsel_reg, row_reg[6:3], col_reg[6:3], 1'b0, row_reg[2:0]});
    assign tile_hi = PAT_AW'({tsel_reg, row_reg[6:3], col_reg[6:3], 1'b1, row_reg[2:0]});

    // Bit 7 of a plane byte is the leftmost pixel of the tile row.
    assign plane_bit = pat_rdata_reg[~col_reg[2:0]];
    assign pixel     = {plane_bit, lsb_reg};

    assign cn  = pal_rdata_reg[5:0];
    assign rgb = vbpps_pkg::master_color(cn);

    assign pat_we = (state_reg == ST_ISSUE) && (op_reg == vbpps_pkg::OP_WRITE) && in_pattern;
    assign pal_we = (state_reg == ST_ISSUE) && (op_reg == vbpps_pkg::OP_WRITE) && in_palette;

    always_comb
    begin
        pat_raddr = addr_reg[PAT_AW-1:0];
        pal_raddr = PAL_AW'(vbpps_pkg::palette_index(addr_reg[4:0]));
        case (state_reg)
            ST_ISSUE:
            begin
                if (op_reg == vbpps_pkg::OP_DRAW)
                begin
                    pat_raddr = tile_lo;
                end
            end
            ST_HIGH:
            begin
                pat_raddr = tile_hi;
            end
            ST_PAL:
            begin
                pal_raddr = PAL_AW'(vbpps_pkg::palette_index({viewer_palette_reg, pixel}));
            end
            default:
            begin
                pat_raddr = addr_reg[PAT_AW-1:0];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                case (op_reg)
                    vbpps_pkg::OP_READ: state_next = ST_READ;
                    vbpps_pkg::OP_DRAW: state_next = ST_HIGH;
                    default:            state_next = ST_IDLE;
                endcase
            end
            ST_READ:  state_next = ST_IDLE;
            ST_HIGH:  state_next = ST_PAL;
            ST_PAL:   state_next = ST_COLOR;
            ST_COLOR: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memories: one synchronous port each; the read port also runs in a write cycle, but a
    // write ends the item and its read data is never used, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[addr_reg[PAT_AW-1:0]] <= wval_reg;
        end
        pat_rdata_reg <= pat_mem[pat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[PAL_AW'(vbpps_pkg::palette_index(addr_reg[4:0]))] <= wval_reg;
        end
        pal_rdata_reg <= pal_mem[pal_raddr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            viewer_palette_reg <= 3'd1;
            done_reg           <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (viewer_palette_we)
            begin
                viewer_palette_reg <= viewer_palette_wdata;
            end
            done_reg <= ((state_reg == ST_ISSUE) && (op_reg != vbpps_pkg::OP_READ)
                                                 && (op_reg != vbpps_pkg::OP_DRAW))
                     || (state_reg == ST_READ)
                     || (state_reg == ST_COLOR);
        end
    end

    // Command capture and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            addr_reg <= bus_address[13:0];
            wval_reg <= write_value;
            tsel_reg <= table_select;
            col_reg  <= pixel_column;
            row_reg  <= pixel_row;
        end
        if (state_reg == ST_HIGH)
        begin
            lsb_reg <= plane_bit;
        end
        case (state_reg)
            ST_ISSUE:
            begin
                read_value_reg   <= 8'd0;
                color_number_reg <= 6'd0;
                rgb_reg          <= 24'd0;
            end
            ST_READ:
            begin
                if (in_pattern)
                begin
                    read_value_reg <= pat_rdata_reg;
                end
                else if (in_palette)
                begin
                    read_value_reg <= pal_rdata_reg;
                end
                else
                begin
                    read_value_reg <= 8'd0;
                end
            end
            ST_COLOR:
            begin
                color_number_reg <= cn;
                rgb_reg          <= rgb;
            end
            default:
            begin
                rgb_reg <= rgb_reg;
            end
        endcase
    end

    assign done         = done_reg;
    assign read_value   = read_value_reg;
    assign color_number = color_number_reg;
    assign red          = rgb_reg[23:16];
    assign green        = rgb_reg[15:8];
    assign blue         = rgb_reg[7:0];

    // A taken command always occupies the sequencer in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("sequencer did not leave idle after a start transfer");

    // A result is only produced at the end of an item's work.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without an item in progress");

    // A bus read result never carries colour fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (read_value != 8'd0)) |-> (color_number == 6'd0))
        else $error("read result carries a colour number");

    // The sequencer state stays one-hot.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state is not one-hot");

endmodule
